>>> design/crps_pkg.sv
// Shared types and constants for the Catmull-Rom path sampler.
package crps_pkg;

   // Basis weight format: signed Q1.16
   localparam int WEIGHT_WIDTH = 18;
   localparam int FRAC_SHIFT   = 16;
   // Width of the samples-per-segment register
   localparam int CFG_WIDTH    = 5;
   // Register value after reset
   localparam int CFG_RESET    = 16;

   // Control point selection for the sample being computed
   typedef enum logic [2:0] {
      PH_SEG_FIRST,   // a, a, b, c
      PH_SEG_MID,     // a, b, c, x
      PH_SEG_LAST,    // b, c, x, x
      PH_RAW_WIN,     // stored point passed through
      PH_RAW_CUR      // current point passed through
   } phase_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic       load;       // capture the accepted request point
      logic       push_req;   // shift the request point into the window
      logic       push_cur;   // shift the captured point into the window
      logic       mul_en;     // register the weighted products
      logic       sum_en;     // register the rounded, saturated sample
      phase_type  phase;
      logic [1:0] k;          // window slot for a pass-through point
      logic       run_last;
      logic       path_end;
   } cmd_type;

endpackage

>>> design/crps_ctrl.sv
// Controller: request handshake, segment and sample sequencing, config register.
module crps_ctrl
   import crps_pkg::*;
#(
   parameter int  MAX_SAMPLES = 16,
   localparam int NW = $clog2(MAX_SAMPLES + 1),
   localparam int SW = $clog2(MAX_SAMPLES)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_path_last,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CFG_WIDTH-1:0] csr_samples_per_segment,
   output cmd_type              cmd,
   output logic [NW-1:0]        n_eff,
   output logic [SW-1:0]        s_idx
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_SUM  = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   phase_type            phase_ff, phase_in;
   logic [SW-1:0]        s_ff, s_in;
   logic [1:0]           k_ff, k_in;
   logic                 last_ff, last_in;
   logic [2:0]           seen_ff, seen_in;
   logic [CFG_WIDTH-1:0] cfg_ff;
   logic                 s_last;
   logic                 final_job;

   // Clamp the configured sample count into 2..MAX_SAMPLES
   always_comb begin
      if (cfg_ff < CFG_WIDTH'(2)) begin
         n_eff = NW'(2);
      end else if (cfg_ff > CFG_WIDTH'(MAX_SAMPLES)) begin
         n_eff = NW'(MAX_SAMPLES);
      end else begin
         n_eff = NW'(cfg_ff);
      end
   end

   assign s_last = (s_ff == SW'(n_eff - NW'(1)));

   // Last sample caused by the current request
   always_comb begin
      unique case (phase_ff)
         PH_SEG_MID: final_job = s_last & ~last_ff;
         PH_RAW_CUR: final_job = 1'b1;
         default:    final_job = 1'b0;
      endcase
   end

   // Config register, to be written only while idle; the block does not enforce this
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_WIDTH'(CFG_RESET);
      end else if (csr_valid) begin
         cfg_ff <= csr_samples_per_segment;
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      s_in     = s_ff;
      k_in     = k_ff;
      last_in  = last_ff;
      seen_in  = seen_ff;
      cmd          = '0;
      cmd.phase    = phase_ff;
      cmd.k        = k_ff;
      cmd.run_last = final_job;
      cmd.path_end = (phase_ff == PH_RAW_CUR);
      cmd.mul_en   = (state_ff == ST_MUL);
      cmd.sum_en   = (state_ff == ST_SUM);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               last_in  = req_path_last;
               s_in     = '0;
               if (seen_ff < 3'd3) begin
                  if (req_path_last) begin
                     // short path: pass stored points and this one through
                     seen_in  = 3'd0;
                     state_in = ST_MUL;
                     if (seen_ff == 3'd0) begin
                        phase_in = PH_RAW_CUR;
                     end else begin
                        phase_in = PH_RAW_WIN;
                        k_in     = 2'(3'd3 - seen_ff);
                     end
                  end else begin
                     cmd.push_req = 1'b1;
                     seen_in      = seen_ff + 3'd1;
                  end
               end else begin
                  phase_in = (seen_ff == 3'd3) ? PH_SEG_FIRST : PH_SEG_MID;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               if (final_job) begin
                  state_in = ST_IDLE;
                  if (last_ff) begin
                     seen_in = 3'd0;
                  end else begin
                     cmd.push_cur = 1'b1;
                     seen_in      = 3'd4;
                  end
               end else begin
                  state_in = ST_MUL;
                  unique case (phase_ff)
                     PH_SEG_FIRST: begin
                        if (s_last) begin
                           phase_in = PH_SEG_MID;
                           s_in     = '0;
                        end else begin
                           s_in = s_ff + SW'(1);
                        end
                     end
                     PH_SEG_MID: begin
                        if (s_last) begin
                           phase_in = PH_SEG_LAST;
                           s_in     = '0;
                        end else begin
                           s_in = s_ff + SW'(1);
                        end
                     end
                     PH_SEG_LAST: begin
                        if (s_last) begin
                           phase_in = PH_RAW_CUR;
                           s_in     = '0;
                        end else begin
                           s_in = s_ff + SW'(1);
                        end
                     end
                     PH_RAW_WIN: begin
                        if (k_ff == 2'd2) begin
                           phase_in = PH_RAW_CUR;
                        end else begin
                           k_in = k_ff + 2'd1;
                        end
                     end
                     default: begin
                        phase_in = phase_ff;
                     end
                  endcase
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_RAW_CUR;
         s_ff     <= '0;
         k_ff     <= '0;
         last_ff  <= 1'b0;
         seen_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         s_ff     <= s_in;
         k_ff     <= k_in;
         last_ff  <= last_in;
         seen_ff  <= seen_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign s_idx     = s_ff;

endmodule

>>> design/crps_dp.sv
// Datapath: point window, basis weight table, multiply, round and saturate.
module crps_dp
   import crps_pkg::*;
#(
   parameter int  MAX_SAMPLES = 16,
   parameter int  COORD_WIDTH = 24,
   localparam int NW = $clog2(MAX_SAMPLES + 1),
   localparam int SW = $clog2(MAX_SAMPLES)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cmd_type                       cmd,
   input  logic [NW-1:0]                 n_eff,
   input  logic [SW-1:0]                 s_idx,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   output logic signed [COORD_WIDTH-1:0] rsp_sample_x,
   output logic signed [COORD_WIDTH-1:0] rsp_sample_y,
   output logic                          rsp_run_last,
   output logic                          rsp_path_end
);

   localparam int PW = WEIGHT_WIDTH + COORD_WIDTH;
   localparam int AW = PW + 2;

   logic signed [COORD_WIDTH-1:0]  win_x_ff [3];
   logic signed [COORD_WIDTH-1:0]  win_y_ff [3];
   logic signed [COORD_WIDTH-1:0]  cur_x_ff, cur_y_ff;
   logic signed [WEIGHT_WIDTH-1:0] wtab [MAX_SAMPLES+1][MAX_SAMPLES][4];
   logic signed [WEIGHT_WIDTH-1:0] w [4];
   logic signed [COORD_WIDTH-1:0]  px [4];
   logic signed [COORD_WIDTH-1:0]  py [4];
   logic signed [PW-1:0]           prod_x_ff [4];
   logic signed [PW-1:0]           prod_y_ff [4];
   logic signed [COORD_WIDTH-1:0]  sample_x_ff, sample_y_ff;
   logic                           run_last_ff, path_end_ff;

   // Basis weight table, worked out at elaboration, ties rounded away from zero
   for (genvar gn = 0; gn <= MAX_SAMPLES; gn++) begin : g_n
      for (genvar gs = 0; gs < MAX_SAMPLES; gs++) begin : g_s
         if (gn >= 2) begin : g_w
            localparam longint N    = gn;
            localparam longint S    = gs;
            localparam longint DEN  = 2 * N * N * N;
            localparam longint ONE  = longint'(1) << FRAC_SHIFT;
            localparam longint NUM0 = -S*S*S + 2*S*S*N - S*N*N;
            localparam longint NUM1 = 3*S*S*S - 5*S*S*N + 2*N*N*N;
            localparam longint NUM2 = -3*S*S*S + 4*S*S*N + S*N*N;
            localparam longint NUM3 = S*S*S - S*S*N;
            localparam longint MAG0 = (NUM0 < 0) ? -NUM0 : NUM0;
            localparam longint MAG1 = (NUM1 < 0) ? -NUM1 : NUM1;
            localparam longint MAG2 = (NUM2 < 0) ? -NUM2 : NUM2;
            localparam longint MAG3 = (NUM3 < 0) ? -NUM3 : NUM3;
            localparam longint Q0   = (MAG0 * ONE + DEN / 2) / DEN;
            localparam longint Q1   = (MAG1 * ONE + DEN / 2) / DEN;
            localparam longint Q2   = (MAG2 * ONE + DEN / 2) / DEN;
            localparam longint Q3   = (MAG3 * ONE + DEN / 2) / DEN;
            localparam longint W0   = (NUM0 < 0) ? -Q0 : Q0;
            localparam longint W1   = (NUM1 < 0) ? -Q1 : Q1;
            localparam longint W2   = (NUM2 < 0) ? -Q2 : Q2;
            localparam longint W3   = (NUM3 < 0) ? -Q3 : Q3;
            assign wtab[gn][gs][0] = WEIGHT_WIDTH'(W0);
            assign wtab[gn][gs][1] = WEIGHT_WIDTH'(W1);
            assign wtab[gn][gs][2] = WEIGHT_WIDTH'(W2);
            assign wtab[gn][gs][3] = WEIGHT_WIDTH'(W3);
         end else begin : g_z
            assign wtab[gn][gs][0] = '0;
            assign wtab[gn][gs][1] = '0;
            assign wtab[gn][gs][2] = '0;
            assign wtab[gn][gs][3] = '0;
         end
      end
   end

   // Point window and captured request point
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            win_x_ff[i] <= '0;
            win_y_ff[i] <= '0;
         end
      end else if (cmd.push_req) begin
         win_x_ff[0] <= win_x_ff[1];
         win_x_ff[1] <= win_x_ff[2];
         win_x_ff[2] <= req_point_x;
         win_y_ff[0] <= win_y_ff[1];
         win_y_ff[1] <= win_y_ff[2];
         win_y_ff[2] <= req_point_y;
      end else if (cmd.push_cur) begin
         win_x_ff[0] <= win_x_ff[1];
         win_x_ff[1] <= win_x_ff[2];
         win_x_ff[2] <= cur_x_ff;
         win_y_ff[0] <= win_y_ff[1];
         win_y_ff[1] <= win_y_ff[2];
         win_y_ff[2] <= cur_y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_x_ff <= req_point_x;
         cur_y_ff <= req_point_y;
      end
   end

   // Control point selection; a pass-through point uses the s = 0 weights
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         px[j] = '0;
         py[j] = '0;
      end
      unique case (cmd.phase)
         PH_SEG_FIRST: begin
            px[0] = win_x_ff[0]; px[1] = win_x_ff[0];
            px[2] = win_x_ff[1]; px[3] = win_x_ff[2];
            py[0] = win_y_ff[0]; py[1] = win_y_ff[0];
            py[2] = win_y_ff[1]; py[3] = win_y_ff[2];
         end
         PH_SEG_MID: begin
            px[0] = win_x_ff[0]; px[1] = win_x_ff[1];
            px[2] = win_x_ff[2]; px[3] = cur_x_ff;
            py[0] = win_y_ff[0]; py[1] = win_y_ff[1];
            py[2] = win_y_ff[2]; py[3] = cur_y_ff;
         end
         PH_SEG_LAST: begin
            px[0] = win_x_ff[1]; px[1] = win_x_ff[2];
            px[2] = cur_x_ff;    px[3] = cur_x_ff;
            py[0] = win_y_ff[1]; py[1] = win_y_ff[2];
            py[2] = cur_y_ff;    py[3] = cur_y_ff;
         end
         PH_RAW_WIN: begin
            unique case (cmd.k)
               2'd1: begin
                  px[1] = win_x_ff[1];
                  py[1] = win_y_ff[1];
               end
               2'd2: begin
                  px[1] = win_x_ff[2];
                  py[1] = win_y_ff[2];
               end
               default: begin
                  px[1] = win_x_ff[0];
                  py[1] = win_y_ff[0];
               end
            endcase
         end
         default: begin
            px[1] = cur_x_ff;
            py[1] = cur_y_ff;
         end
      endcase
   end

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         w[j] = (cmd.phase == PH_RAW_WIN || cmd.phase == PH_RAW_CUR) ?
                wtab[n_eff][0][j] : wtab[n_eff][s_idx][j];
      end
   end

   // Product stage: one multiplier per control point and axis
   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         for (int j = 0; j < 4; j++) begin
            prod_x_ff[j] <= PW'(w[j]) * PW'(px[j]);
            prod_y_ff[j] <= PW'(w[j]) * PW'(py[j]);
         end
      end
   end

   // Sum, round half up at bit 16, saturate to the coordinate width
   function automatic logic signed [COORD_WIDTH-1:0] combine(
      input logic signed [PW-1:0] p0,
      input logic signed [PW-1:0] p1,
      input logic signed [PW-1:0] p2,
      input logic signed [PW-1:0] p3
   );
      logic signed [AW-1:0] acc;
      logic signed [AW-1:0] shifted;
      logic                 fits;
      acc = AW'(p0) + AW'(p1) + AW'(p2) + AW'(p3)
            + AW'(longint'(1) << (FRAC_SHIFT - 1));
      shifted = acc >>> FRAC_SHIFT;
      fits = (shifted[AW-1:COORD_WIDTH-1] == '0) || (shifted[AW-1:COORD_WIDTH-1] == '1);
      if (fits) begin
         combine = shifted[COORD_WIDTH-1:0];
      end else if (shifted[AW-1]) begin
         combine = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
         combine = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end
   endfunction

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.sum_en) begin
         sample_x_ff <= combine(prod_x_ff[0], prod_x_ff[1], prod_x_ff[2], prod_x_ff[3]);
         sample_y_ff <= combine(prod_y_ff[0], prod_y_ff[1], prod_y_ff[2], prod_y_ff[3]);
         run_last_ff <= cmd.run_last;
         path_end_ff <= cmd.path_end;
      end
   end

   assign rsp_sample_x = sample_x_ff;
   assign rsp_sample_y = sample_y_ff;
   assign rsp_run_last = run_last_ff;
   assign rsp_path_end = path_end_ff;

endmodule

>>> design/catmull_rom_path_sampler.sv
// Top level of the Catmull-Rom path sampler: controller plus datapath.
// Takes path points one request at a time and emits a uniform Catmull-Rom
// spline (tension 0.5) with N = samples_per_segment samples per segment
// (clamped to 2..MAX_SAMPLES); paths shorter than four points pass through
// unchanged. For each output sample the weighted products are registered,
// then the rounded and saturated sum is registered, then the sample sits in
// the output register and leaves in that cycle if the receiver is ready;
// the output waits while it is not. The first three points of a path cause
// no samples unless one of them is last, in which case the stored points and
// the last one pass through (one to three samples). The fourth point causes
// 2N samples, later points N each, and the last point of a long path 2N+1
// (3N+1 when it is the fourth point). The request port is held until all of
// its samples are delivered. The config register may be written only while
// the block is idle.
module catmull_rom_path_sampler
   import crps_pkg::*;
#(
   parameter int MAX_SAMPLES = 16,
   parameter int COORD_WIDTH = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic                          req_path_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_WIDTH-1:0] rsp_sample_x,
   output logic signed [COORD_WIDTH-1:0] rsp_sample_y,
   output logic                          rsp_run_last,
   output logic                          rsp_path_end,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CFG_WIDTH-1:0]          csr_samples_per_segment
);

   localparam int NW = $clog2(MAX_SAMPLES + 1);
   localparam int SW = $clog2(MAX_SAMPLES);

   cmd_type       cmd;
   logic [NW-1:0] n_eff;
   logic [SW-1:0] s_idx;

   crps_ctrl #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_ctrl (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_path_last           (req_path_last),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_samples_per_segment (csr_samples_per_segment),
      .cmd                     (cmd),
      .n_eff                   (n_eff),
      .s_idx                   (s_idx)
   );

   crps_dp #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .n_eff        (n_eff),
      .s_idx        (s_idx),
      .req_point_x  (req_point_x),
      .req_point_y  (req_point_y),
      .rsp_sample_x (rsp_sample_x),
      .rsp_sample_y (rsp_sample_y),
      .rsp_run_last (rsp_run_last),
      .rsp_path_end (rsp_path_end)
   );

endmodule
